// ----- rtl/core/urav_pkg.sv -----
`default_nettype none

package urav_pkg;

	localparam int WINDOW_DEF     = 8;
	localparam int COUNT_BITS_DEF = 24;

	// result queue ahead of the result port; the input credit check uses the same depth
	localparam int OFIFO_DEPTH = 8;
	localparam int OF_PTR_W    = $clog2(OFIFO_DEPTH);
	localparam int OF_CNT_W    = OF_PTR_W + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_PRE_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 3'd4;

	localparam logic [7:0]  PRE_LOW_RST   = 8'd2;
	localparam logic [7:0]  TRIG_HIGH_RST = 8'd10;
	localparam logic [23:0] TIMEOUT_RST   = 24'd100000;
	localparam logic [15:0] SCALE_RST     = 16'd17984;
	localparam logic [15:0] MIN_DIST_RST  = 16'd64;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} sample_t;

	typedef struct packed {
		logic        trig_level;
		logic        busy_res;
		logic        done_res;
		logic        fail;
		logic [15:0] distance_avg;
	} result_t;

	typedef struct packed {
		logic [7:0]  pre_low_ticks;
		logic [7:0]  trig_high_ticks;
		logic [23:0] timeout_ticks;
		logic [15:0] distance_scale;
		logic [15:0] min_distance;
	} cfg_t;

	// per-beat control carried down the pipeline
	typedef struct packed {
		logic vld;
		logic trig;
		logic busy;
		logic done;
		logic fail;
		logic meas;
	} stage_flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/urav_seq.sv -----
`default_nettype none

module urav_seq
	import urav_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  take,
	input  wire sample_t               smp,
	output stage_flags_t               flg_s2,
	output logic [COUNT_BITS-1:0]      width_s2
);

	localparam int CNT_W = COUNT_BITS;
	localparam logic [63:0] CNT_LIM64 = (64'd1 << COUNT_BITS) - 64'd1;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_PRE  = 5'b00010,
		PH_HIGH = 5'b00100,
		PH_RISE = 5'b01000,
		PH_FALL = 5'b10000
	} phase_t;

	sample_t           smp_s1;
	logic              vld_s1;
	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  width_q, width_d;
	logic [CNT_W-1:0]  tmo;
	stage_flags_t      flg_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			smp_s1 <= smp;
		end
	end

	// timeout above the counter range acts as the counter limit
	always_comb begin
		if (64'(cfg.timeout_ticks) > CNT_LIM64) begin
			tmo = '1;
		end else begin
			tmo = CNT_W'(cfg.timeout_ticks);
		end
	end

	always_comb begin
		phase_t           ph;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] w;
		logic [CNT_W-1:0] cinc;
		logic [CNT_W-1:0] winc;
		ph    = phase_q;
		cnt   = count_q;
		w     = width_q;
		flg_d = '0;
		flg_d.vld = vld_s1;
		if (ph == PH_IDLE && smp_s1.start_req) begin
			ph  = (cfg.pre_low_ticks != 8'd0) ? PH_PRE : PH_HIGH;
			cnt = '0;
			w   = '0;
		end
		cinc = (cnt != '1) ? cnt + CNT_W'(1) : cnt;
		winc = (w != '1) ? w + CNT_W'(1) : w;
		case (ph)
			PH_PRE: begin
				flg_d.busy = 1'b1;
				cnt = cinc;
				if (cinc >= CNT_W'(cfg.pre_low_ticks)) begin
					ph  = PH_HIGH;
					cnt = '0;
				end
			end
			PH_HIGH: begin
				flg_d.busy = 1'b1;
				flg_d.trig = 1'b1;
				cnt = cinc;
				// zero high time still gives one tick
				if (cinc >= CNT_W'(cfg.trig_high_ticks)) begin
					ph  = PH_RISE;
					cnt = '0;
				end
			end
			PH_RISE: begin
				if (smp_s1.echo_level) begin
					flg_d.busy = 1'b1;
					w   = CNT_W'(1);
					ph  = PH_FALL;
					cnt = '0;
				end else if (cinc >= tmo) begin
					flg_d.done = 1'b1;
					flg_d.fail = 1'b1;
					ph  = PH_IDLE;
					cnt = '0;
				end else begin
					flg_d.busy = 1'b1;
					cnt = cinc;
				end
			end
			PH_FALL: begin
				cnt = '0;
				if (smp_s1.echo_level) begin
					w = winc;
					if (winc >= tmo) begin
						flg_d.done = 1'b1;
						flg_d.fail = 1'b1;
						ph = PH_IDLE;
					end else begin
						flg_d.busy = 1'b1;
					end
				end else begin
					// falling edge: width goes on to the distance stages
					flg_d.done = 1'b1;
					flg_d.meas = 1'b1;
					ph = PH_IDLE;
				end
			end
			default: begin
				ph  = PH_IDLE;
				cnt = '0;
			end
		endcase
		phase_d = ph;
		count_d = cnt;
		width_d = w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			width_q <= '0;
			flg_s2  <= '0;
		end else begin
			flg_s2 <= flg_d;
			if (vld_s1) begin
				phase_q <= phase_d;
				count_q <= count_d;
				width_q <= width_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		width_s2 <= width_d;
	end

endmodule

`default_nettype wire

// ----- rtl/core/urav_dist.sv -----
`default_nettype none

module urav_dist
	import urav_pkg::*;
#(
	parameter int WINDOW     = WINDOW_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire stage_flags_t          flg_s2,
	input  wire logic [COUNT_BITS-1:0] width_s2,
	output logic                       res_vld,
	output result_t                    res
);

	localparam int CNT_W  = COUNT_BITS;
	localparam int PROD_W = CNT_W + 16;
	localparam int RND_W  = CNT_W + 17;
	localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int DIV_L  = $clog2(WINDOW);
	localparam int SUM_W  = 16 + DIV_L;
	localparam int X_W    = SUM_W + 1;
	localparam int DIV_SHIFT = X_W + DIV_L;
	localparam int MP_W   = 2 * X_W + 1;
	// mean = (sum + WINDOW/2) / WINDOW by reciprocal, exact for X_W-bit dividends
	localparam logic [63:0] RECIP64 =
		((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [X_W:0]   RECIP = RECIP64[X_W:0];
	localparam logic [X_W-1:0] HALF  = X_W'(WINDOW / 2);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

	stage_flags_t      flg_s3, flg_s4, flg_c;
	logic [PROD_W-1:0] prod_s3;

	logic [15:0]       win_mem [WINDOW];
	logic [WINDOW-1:0] ent_vld_q;
	logic [15:0]       rd_q;
	logic [IDX_W-1:0]  oldest_q;
	logic [SUM_W-1:0]  sum_q;

	logic [RND_W-1:0]  rnd;
	logic [RND_W-1:0]  d_full;
	logic [15:0]       d16;
	logic [15:0]       old_val;
	logic              too_close;
	logic              push;
	logic [X_W-1:0]    mx;
	logic [MP_W-1:0]   mprod;

	// stage B: scale the width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_s3 <= '0;
		end else begin
			flg_s3 <= flg_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= PROD_W'(width_s2) * PROD_W'(cfg.distance_scale);
	end

	// stage C: round, saturate, qualify, update the window
	always_comb begin
		rnd    = RND_W'(prod_s3) + RND_W'(32768);
		d_full = rnd >> 16;
		if (d_full > RND_W'(65535)) begin
			d16 = 16'hFFFF;
		end else begin
			d16 = d_full[15:0];
		end
		too_close = (d16 <= cfg.min_distance);
		push      = flg_s3.vld && flg_s3.meas && !too_close;
		old_val   = ent_vld_q[oldest_q] ? rd_q : 16'd0;
		flg_c      = flg_s3;
		flg_c.fail = flg_s3.fail || (flg_s3.meas && too_close);
		flg_c.meas = push;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			win_mem[oldest_q] <= d16;
		end
		// pushes are several beats apart, so the registered read of the oldest entry never lags a push
		rd_q <= win_mem[oldest_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_s4    <= '0;
			ent_vld_q <= '0;
			oldest_q  <= '0;
			sum_q     <= '0;
		end else begin
			flg_s4 <= flg_c;
			if (push) begin
				ent_vld_q[oldest_q] <= 1'b1;
				oldest_q <= (oldest_q == IDX_LAST) ? '0 : oldest_q + IDX_W'(1);
				sum_q    <= sum_q - SUM_W'(old_val) + SUM_W'(d16);
			end
		end
	end

	// stage D: rounded mean of the window
	always_comb begin
		mx    = X_W'(sum_q) + HALF;
		mprod = MP_W'(mx) * MP_W'(RECIP);
		res_vld          = flg_s4.vld;
		res.trig_level   = flg_s4.trig;
		res.busy_res     = flg_s4.busy;
		res.done_res     = flg_s4.done;
		res.fail         = flg_s4.fail;
		res.distance_avg = flg_s4.meas ? mprod[DIV_SHIFT +: 16] : 16'd0;
	end

endmodule

`default_nettype wire

// ----- rtl/core/urav_ofifo.sv -----
`default_nettype none

module urav_ofifo
	import urav_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t din,
	input  wire logic    pop,
	output result_t      dout,
	output logic         not_empty
);

	result_t             mem [OFIFO_DEPTH];
	logic [OF_PTR_W-1:0] wr_q;
	logic [OF_PTR_W-1:0] rd_q;
	logic [OF_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + OF_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + OF_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + OF_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - OF_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign dout      = mem[rd_q];
	assign not_empty = (cnt_q != '0);

endmodule

`default_nettype wire

// ----- rtl/core/ultrasonic_ranger_averaged.sv -----
// Ultrasonic echo ranger with a moving-average filter.
// sample channel: one beat per tick of the pin sampler (start_req, echo_level).
// result channel: exactly one beat per sample beat, in order: trigger level,
//   busy, done, fail and the rounded window mean (nonzero only on a good done).
// cfg channel: cfg_index/cfg_data write one register (0 pre-low ticks, 1 trigger
//   high ticks, 2 echo timeout, 3 Q16 scale, 4 minimum distance); cfg_ready is
//   always high. Write only while no sample beat is outstanding.
// Pipeline: a sample beat passes the input register, sequencer, scale multiply and window
//   update registers, then the combinational mean multiply, into the result queue.
// Throughput: one sample per cycle, sustained. The input is held off only when
//   eight beats are taken and not yet delivered; an eight-entry result queue
//   absorbs result stalls, so sample_stall never follows result_stall directly.
// Reset: sequencer idle, counters and the averaging window cleared to zero,
//   registers back to their defaults, result queue empty.
`default_nettype none

module ultrasonic_ranger_averaged
	import urav_pkg::*;
#(
	parameter int WINDOW     = WINDOW_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  sample_valid,
	output logic                       sample_stall,
	input  wire sample_t               sample,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                  cfg_q;
	logic                  take;
	logic                  give;
	logic [OF_CNT_W-1:0]   pend_q;
	stage_flags_t          flg_s2;
	logic [COUNT_BITS-1:0] width_s2;
	logic                  res_vld;
	result_t               res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_low_ticks   <= PRE_LOW_RST;
			cfg_q.trig_high_ticks <= TRIG_HIGH_RST;
			cfg_q.timeout_ticks   <= TIMEOUT_RST;
			cfg_q.distance_scale  <= SCALE_RST;
			cfg_q.min_distance    <= MIN_DIST_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PRE_LOW:   cfg_q.pre_low_ticks   <= cfg_data[7:0];
				REG_TRIG_HIGH: cfg_q.trig_high_ticks <= cfg_data[7:0];
				REG_TIMEOUT:   cfg_q.timeout_ticks   <= cfg_data[23:0];
				REG_SCALE:     cfg_q.distance_scale  <= cfg_data[15:0];
				REG_MIN_DIST:  cfg_q.min_distance    <= cfg_data[15:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// beats in flight plus queued results never exceed the queue depth
	assign sample_stall = (pend_q >= OF_CNT_W'(OFIFO_DEPTH));
	assign take         = sample_valid && !sample_stall;
	assign give         = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({take, give})
				2'b10:   pend_q <= pend_q + OF_CNT_W'(1);
				2'b01:   pend_q <= pend_q - OF_CNT_W'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	urav_seq #(
		.COUNT_BITS(COUNT_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.take     (take),
		.smp      (sample),
		.flg_s2   (flg_s2),
		.width_s2 (width_s2)
	);

	urav_dist #(
		.WINDOW     (WINDOW),
		.COUNT_BITS (COUNT_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.flg_s2   (flg_s2),
		.width_s2 (width_s2),
		.res_vld  (res_vld),
		.res      (res)
	);

	urav_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_vld),
		.din       (res),
		.pop       (give),
		.dout      (result),
		.not_empty (result_valid)
	);

endmodule

`default_nettype wire

// ----- rtl/core/urav_chk.sv -----
`default_nettype none

module urav_chk
	import urav_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// a finishing beat is never also a busy beat
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> !result.busy_res)
		else $error("done and busy on the same result beat");

	// fail and a distance only come with done, and never together
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.fail || result.distance_avg != 16'd0)
		|-> result.done_res && !(result.fail && result.distance_avg != 16'd0))
		else $error("fail or distance outside a clean done beat");

	// the trigger is only driven inside a measurement
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.trig_level |-> result.busy_res)
		else $error("trigger high outside a measurement");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed or dropped");

endmodule

bind ultrasonic_ranger_averaged urav_chk u_urav_chk (.*);

`default_nettype wire

// ----- dv/tb_ultrasonic_ranger_averaged.sv -----
`timescale 1ns / 100ps

module tb_ultrasonic_ranger_averaged;
	import urav_pkg::*;

	localparam int STUCK_LIMIT = 3000;
	localparam int RAND_ITEMS  = 360;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_TICKS = 8;
	localparam int ECHO_TICKS  = 40;
	localparam int SUM_W       = $clog2(WINDOW_DEF) + 16;

	// indexes past the last register; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_PRE_LOW,
		SEQ_TRIG,
		SEQ_WAIT_RISE,
		SEQ_WAIT_FALL
	} seq_t;

	typedef struct {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
	} reg_wr_t;

	typedef struct {
		bit      is_reg;
		bit      st;
		bit      ec;
		bit      typed_ok;
		result_t res;
		reg_wr_t wr;
	} stim_row_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	sample_t               sample       = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	bit        quiet            = 1'b0;
	bit        hold_off_pending = 1'b0;
	int        mismatches       = 0;
	int        samples_sent     = 0;
	int        results_seen     = 0;
	int        idle_cycles      = 0;
	result_t   pending_results[$];
	reg_wr_t   reg_writes[$];
	stim_row_t dir_rows[$];

	// shadow of the ranger: registers, sequencer and averaging window
	cfg_t                      ranger_regs = '{PRE_LOW_RST, TRIG_HIGH_RST, TIMEOUT_RST,
		SCALE_RST, MIN_DIST_RST};
	seq_t                      seq_st      = SEQ_IDLE;
	logic [COUNT_BITS_DEF-1:0] seq_cnt     = '0;
	logic [COUNT_BITS_DEF-1:0] echo_ticks  = '0;
	logic [15:0]               win_mem [WINDOW_DEF] = '{default: '0};
	logic [SUM_W-1:0]          win_sum     = '0;
	int                        win_ptr     = 0;

	ultrasonic_ranger_averaged u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic [COUNT_BITS_DEF-1:0] bump(logic [COUNT_BITS_DEF-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic result_t next_tick_result(sample_t s);
		result_t     r;
		logic [40:0] prod;
		logic [24:0] dist_raw;
		logic [15:0] d16;
		logic [19:0] acc;
		r = '0;
		if (seq_st == SEQ_IDLE && s.start_req) begin
			seq_st     = (ranger_regs.pre_low_ticks != 0) ? SEQ_PRE_LOW : SEQ_TRIG;
			seq_cnt    = '0;
			echo_ticks = '0;
		end
		case (seq_st)
			SEQ_PRE_LOW: begin
				r.busy_res = 1'b1;
				seq_cnt = bump(seq_cnt);
				if (seq_cnt >= ranger_regs.pre_low_ticks) begin
					seq_st  = SEQ_TRIG;
					seq_cnt = '0;
				end
			end
			SEQ_TRIG: begin
				r.busy_res   = 1'b1;
				r.trig_level = 1'b1;
				seq_cnt = bump(seq_cnt);
				// zero high time still gives one trigger tick
				if (seq_cnt >= ranger_regs.trig_high_ticks) begin
					seq_st  = SEQ_WAIT_RISE;
					seq_cnt = '0;
				end
			end
			SEQ_WAIT_RISE: begin
				if (s.echo_level) begin
					r.busy_res = 1'b1;
					echo_ticks = COUNT_BITS_DEF'(1);
					seq_st     = SEQ_WAIT_FALL;
					seq_cnt    = '0;
				end else begin
					seq_cnt = bump(seq_cnt);
					if (seq_cnt >= ranger_regs.timeout_ticks) begin
						r.done_res = 1'b1;
						r.fail     = 1'b1;
						seq_st     = SEQ_IDLE;
						seq_cnt    = '0;
					end else begin
						r.busy_res = 1'b1;
					end
				end
			end
			SEQ_WAIT_FALL: begin
				if (s.echo_level) begin
					echo_ticks = bump(echo_ticks);
					if (echo_ticks >= ranger_regs.timeout_ticks) begin
						r.done_res = 1'b1;
						r.fail     = 1'b1;
						seq_st     = SEQ_IDLE;
					end else begin
						r.busy_res = 1'b1;
					end
				end else begin
					// Q16 product, round half up, clip to 16 bits
					prod = echo_ticks * ranger_regs.distance_scale + 41'd32768;
					dist_raw = prod[40:16];
					d16  = (dist_raw > 25'd65535) ? 16'hFFFF : dist_raw[15:0];
					r.done_res = 1'b1;
					seq_st     = SEQ_IDLE;
					if (d16 <= ranger_regs.min_distance) begin
						r.fail = 1'b1;
					end else begin
						win_sum = win_sum - win_mem[win_ptr] + d16;
						win_mem[win_ptr] = d16;
						win_ptr = (win_ptr + 1) % WINDOW_DEF;
						acc = {1'b0, win_sum} + 20'(WINDOW_DEF / 2);
						r.distance_avg = 16'(acc / WINDOW_DEF);
					end
				end
				seq_cnt = '0;
			end
			default: begin
				seq_st  = SEQ_IDLE;
				seq_cnt = '0;
			end
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("%0t: beat %0d: %s", $time, results_seen, what);
	endtask

	task automatic send_sample(input bit st, input bit ec, input bit typed_ok = 1'b0,
		input result_t typed = '0);
		int      gap;
		sample_t s;
		result_t predicted;
		s.start_req  = st;
		s.echo_level = ec;
		gap = quiet ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (!(sample_valid && !sample_stall));
		predicted = next_tick_result(s);
		pending_results.push_back(typed_ok ? typed : predicted);
		samples_sent++;
	endtask

	task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		reg_wr_t w;
		w.idx = idx;
		w.val = val;
		reg_writes.push_back(w);
	endtask

	// registers only change once every sample beat has come back
	task automatic apply_writes();
		reg_wr_t w;
		sample_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		while (reg_writes.size() != 0) begin
			w = reg_writes.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data  <= w.val;
			do @(posedge clk); while (!(cfg_valid && cfg_ready));
			case (w.idx)
				REG_PRE_LOW:   ranger_regs.pre_low_ticks   = w.val[7:0];
				REG_TRIG_HIGH: ranger_regs.trig_high_ticks = w.val[7:0];
				REG_TIMEOUT:   ranger_regs.timeout_ticks   = w.val[23:0];
				REG_SCALE:     ranger_regs.distance_scale  = w.val[15:0];
				REG_MIN_DIST:  ranger_regs.min_distance    = w.val[15:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic stim_row_t x_row(bit st, bit ec, bit tg, bit by, bit dn, bit fl,
		logic [15:0] av);
		stim_row_t r;
		r.is_reg   = 1'b0;
		r.st       = st;
		r.ec       = ec;
		r.typed_ok = 1'b1;
		r.res      = '{tg, by, dn, fl, av};
		r.wr.idx   = '0;
		r.wr.val   = '0;
		return r;
	endfunction

	function automatic stim_row_t t_row(bit st, bit ec);
		stim_row_t r;
		r = x_row(st, ec, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
		r.typed_ok = 1'b0;
		return r;
	endfunction

	function automatic stim_row_t r_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = t_row(1'b0, 1'b0);
		r.is_reg = 1'b1;
		r.wr.idx = idx;
		r.wr.val = val;
		return r;
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				flag_mismatch("result beat with nothing pending");
			end else begin
				want = pending_results.pop_front();
				if (result.trig_level !== want.trig_level)
					flag_mismatch($sformatf("trig_level %b, wanted %b",
						result.trig_level, want.trig_level));
				if (result.busy_res !== want.busy_res)
					flag_mismatch($sformatf("busy_res %b, wanted %b",
						result.busy_res, want.busy_res));
				if (result.done_res !== want.done_res)
					flag_mismatch($sformatf("done_res %b, wanted %b",
						result.done_res, want.done_res));
				if (result.fail !== want.fail)
					flag_mismatch($sformatf("fail %b, wanted %b", result.fail, want.fail));
				if (result.distance_avg !== want.distance_avg)
					flag_mismatch($sformatf("distance_avg %0d, wanted %0d",
						result.distance_avg, want.distance_avg));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STUCK_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : result_sink
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 12);
			if (hold_off_pending) begin
				// long back-pressure so the result queue fills and the input stalls
				hold_off_pending = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap != 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	initial begin : stimulus
		int pre, hi, tmo, scale, hi_eff, tmo_eff, rand_base;
		bit first;

		// power-up registers, block idle: nothing moves
		dir_rows.push_back(x_row(0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(x_row(0, 1, 0, 0, 0, 0, 0));
		// no pre-low, zero high time, three-tick timeout, full scale, no minimum
		dir_rows.push_back(r_row(REG_PRE_LOW, 24'd0));
		dir_rows.push_back(r_row(REG_TRIG_HIGH, 24'd0));
		dir_rows.push_back(r_row(REG_TIMEOUT, 24'd3));
		dir_rows.push_back(r_row(REG_SCALE, 24'h00FFFF));
		dir_rows.push_back(r_row(REG_MIN_DIST, 24'd0));
		// echo already high on the first wait tick; one-tick width gives distance 1, mean 0
		dir_rows.push_back(x_row(1, 1, 1, 1, 0, 0, 0));
		dir_rows.push_back(x_row(0, 1, 0, 1, 0, 0, 0));
		dir_rows.push_back(x_row(0, 0, 0, 0, 1, 0, 0));
		// echo never rises; a start on the done tick is dropped
		dir_rows.push_back(x_row(1, 0, 1, 1, 0, 0, 0));
		dir_rows.push_back(x_row(0, 0, 0, 1, 0, 0, 0));
		dir_rows.push_back(x_row(0, 0, 0, 1, 0, 0, 0));
		dir_rows.push_back(x_row(1, 0, 0, 0, 1, 1, 0));
		dir_rows.push_back(x_row(0, 0, 0, 0, 0, 0, 0));
		// echo stuck high
		dir_rows.push_back(x_row(1, 1, 1, 1, 0, 0, 0));
		dir_rows.push_back(x_row(0, 1, 0, 1, 0, 0, 0));
		dir_rows.push_back(x_row(0, 1, 0, 1, 0, 0, 0));
		dir_rows.push_back(x_row(0, 1, 0, 0, 1, 1, 0));
		// oversized data gets masked, spare indexes dropped, zero timeout, all too close
		dir_rows.push_back(r_row(REG_PRE_LOW, 24'hFFFF03));
		dir_rows.push_back(r_row(REG_TRIG_HIGH, 24'hABCD01));
		dir_rows.push_back(r_row(REG_SPARE_5, 24'hFFFFFF));
		dir_rows.push_back(r_row(REG_SPARE_7, 24'h000000));
		dir_rows.push_back(r_row(REG_TIMEOUT, 24'd0));
		dir_rows.push_back(r_row(REG_MIN_DIST, 24'hFFFFFF));
		dir_rows.push_back(t_row(1, 0));
		dir_rows.push_back(t_row(0, 1));
		dir_rows.push_back(t_row(0, 0));
		dir_rows.push_back(t_row(0, 0));
		dir_rows.push_back(t_row(0, 0));
		dir_rows.push_back(t_row(1, 0));
		dir_rows.push_back(t_row(0, 0));
		dir_rows.push_back(t_row(0, 0));
		dir_rows.push_back(t_row(0, 0));
		dir_rows.push_back(t_row(0, 1));
		dir_rows.push_back(t_row(0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg) begin
				reg_writes.push_back(dir_rows[i].wr);
			end else begin
				if (reg_writes.size() != 0)
					apply_writes();
				send_sample(dir_rows[i].st, dir_rows[i].ec, dir_rows[i].typed_ok,
					dir_rows[i].res);
			end
		end

		// widest registers, timeout at the counter limit
		queue_write(REG_PRE_LOW, 24'd255);
		queue_write(REG_TRIG_HIGH, 24'd255);
		queue_write(REG_TIMEOUT, 24'hFFFFFF);
		queue_write(REG_SCALE, 24'h00FFFF);
		queue_write(REG_MIN_DIST, 24'd0);
		apply_writes();
		quiet = 1'b1;
		send_sample(1, 0);
		repeat (255 + 255 - 1) send_sample(0, 0);
		repeat (ECHO_TICKS) send_sample(0, 1);
		send_sample(0, 0);
		quiet = 1'b0;

		rand_base = samples_sent;
		first = 1'b1;
		while (samples_sent - rand_base < RAND_ITEMS) begin
			pre   = $urandom_range(0, 4);
			hi    = $urandom_range(0, 4);
			tmo   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 30);
			scale = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 65535);
			queue_write(REG_PRE_LOW, CFG_DATA_W'(pre));
			queue_write(REG_TRIG_HIGH, CFG_DATA_W'(hi));
			queue_write(REG_TIMEOUT, CFG_DATA_W'(tmo));
			queue_write(REG_SCALE, CFG_DATA_W'(scale));
			queue_write(REG_MIN_DIST,
				CFG_DATA_W'($urandom_range(0, ((scale * tmo) >> 17) + 1)));
			apply_writes();
			hi_eff  = (hi == 0) ? 1 : hi;
			tmo_eff = (tmo == 0) ? 1 : tmo;
			quiet = first ? 1'b0 : ($urandom_range(0, 3) == 0);
			if (first)
				hold_off_pending = 1'b1;
			first = 1'b0;
			repeat ($urandom_range(6, 14)) begin
				repeat ($urandom_range(0, 3))
					send_sample($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 7) == 0) begin
					// broken sequence: random pin activity
					repeat ($urandom_range(1, 20))
						send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end else begin
					send_sample(1, 1'($urandom_range(0, 1)));
					repeat (pre + hi_eff - 1)
						send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					repeat ($urandom_range(0, tmo_eff))
						send_sample(1'($urandom_range(0, 1)), 0);
					repeat ($urandom_range(1, tmo_eff + 1))
						send_sample(0, 1);
					send_sample(1'($urandom_range(0, 1)), 0);
				end
			end
		end

		sample_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/urav_pkg.sv
rtl/core/urav_seq.sv
rtl/core/urav_dist.sv
rtl/core/urav_ofifo.sv
rtl/core/ultrasonic_ranger_averaged.sv
rtl/core/urav_chk.sv
dv/tb_ultrasonic_ranger_averaged.sv
